FILE: design/dpl_pkg.sv
// Shared constants for the demand paging core with LRU frame replacement.
// No dependencies; imported by dpl_cell, demand_paging_lru_core and the testbench.
package dpl_pkg;

   localparam int PAGE_W          = 3;
   localparam int FRAME_W         = 2;
   localparam int CFG_W           = 3;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_DATA_W      = 8;
   localparam int NUM_PAGES_DEF   = 8;
   localparam int NUM_FRAMES_DEF  = 4;
   localparam logic [CFG_W-1:0] FRAMES_RESET = 3'd4;

endpackage

FILE: design/demand_paging_lru_core.sv
// Demand paging core: resident-page lookup with LRU frame replacement.
// Built from a chain of dpl_cell frame cells; uses dpl_pkg.
//
// Usage:
//   req_ channel: one page read request per transfer, page number in tdata.
//   rsp_ channel: one result per request, in request order, from an output
//     register, so the next request is taken while a result still waits.
//   csr_ port: frames_in_use, written only while the core is idle (not enforced by the core).
// Steps per request, from accept to result valid:
//   hit or page out of range: accept, match, result load.
//   miss: accept, match, scan, result load; the free/victim scan token walks the
//   cell chain one frame per cycle.
//   A new request is taken in the cycle after the result is loaded.
// Reset: every frame free, no page resident, frames_in_use back to 4.
// Stall: while rsp_tready is low the result holds; a finished next request
//   waits in its final state until the output register frees up.
module demand_paging_lru_core #(
   parameter int NUM_PAGES  = dpl_pkg::NUM_PAGES_DEF,
   parameter int NUM_FRAMES = dpl_pkg::NUM_FRAMES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] page_number, [7:3] zero
   input  logic [dpl_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] frame_number, [2] page_fault, [3] evicted, [6:4] evicted_page, [7] zero
   output logic [dpl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [dpl_pkg::CFG_W-1:0]        csr_wr_data
);
   import dpl_pkg::*;

   localparam int FI_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);
   localparam int TOK_W  = 3 * FI_W + 3;
   localparam int CMD_W  = FI_W + CNT_W + 2;
   localparam int STAT_W = FI_W + PAGE_W + 2;

   typedef struct packed {
      logic            vld;
      logic            free_found;
      logic [FI_W-1:0] free_idx;
      logic            have;
      logic [FI_W-1:0] best_rank;
      logic [FI_W-1:0] best_idx;
   } tok_type;

   typedef struct packed {
      logic             touch;
      logic             load;
      logic [FI_W-1:0]  frame;
      logic [CNT_W-1:0] old;
   } cmd_type;

   typedef struct packed {
      logic              used;
      logic              hit;
      logic [PAGE_W-1:0] owner;
      logic [FI_W-1:0]   rank;
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  frames_ff;
   logic [CNT_W-1:0]  limit;
   logic [PAGE_W-1:0] page_ff;
   logic [FI_W-1:0]   f_ff, f_in;
   logic              fault_ff, fault_in, ev_ff, ev_in, skip_ff, skip_in;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              out_free, oor;

   tok_type           tok_w [NUM_FRAMES+1];
   stat_type          stat_w [NUM_FRAMES];
   cmd_type           cmd;
   tok_type           tok_last;

   logic [NUM_FRAMES-1:0] hit_vec;
   logic              hit_any, used_f;
   logic [FI_W-1:0]   hit_idx, rank_f;
   logic [PAGE_W-1:0] owner_f;

   always_comb begin
      if (frames_ff == '0) begin
         limit = CNT_W'(1);
      end else if (int'(frames_ff) > NUM_FRAMES) begin
         limit = CNT_W'(NUM_FRAMES);
      end else begin
         limit = CNT_W'(frames_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else if (csr_wr_en) begin
         frames_ff <= csr_wr_data;
      end
   end

   assign oor = int'(page_ff) >= NUM_PAGES;

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      used_f  = 1'b0;
      rank_f  = '0;
      owner_f = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         hit_vec[i] = stat_w[i].hit;
         if (stat_w[i].hit) begin
            hit_any = 1'b1;
            hit_idx = hit_idx | FI_W'(i);
         end
         if (f_ff == FI_W'(i)) begin
            used_f  = used_f | stat_w[i].used;
            rank_f  = rank_f | stat_w[i].rank;
            owner_f = owner_f | stat_w[i].owner;
         end
      end
   end

   assign tok_last = tok_w[NUM_FRAMES];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      tok_w[0]     = '0;
      tok_w[0].vld = (state_ff == S_MATCH) && !oor && !hit_any;
   end

   always_comb begin
      state_in = state_ff;
      f_in     = f_ff;
      fault_in = fault_ff;
      ev_in    = ev_ff;
      skip_in  = skip_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            fault_in = 1'b0;
            ev_in    = 1'b0;
            skip_in  = oor;
            f_in     = (oor || !hit_any) ? '0 : hit_idx;
            state_in = (oor || hit_any) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            if (tok_last.vld) begin
               fault_in = 1'b1;
               ev_in    = !tok_last.free_found;
               f_in     = tok_last.free_found ? tok_last.free_idx : tok_last.best_idx;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.touch = !skip_ff;
               cmd.load  = fault_ff;
               cmd.frame = f_ff;
               cmd.old   = used_f ? CNT_W'(rank_f) : CNT_W'(NUM_FRAMES);
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         page_ff <= req_tdata[PAGE_W-1:0];
      end
      f_ff     <= f_in;
      fault_ff <= fault_in;
      ev_ff    <= ev_in;
      skip_ff  <= skip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_data_ff <= {1'b0, (ev_ff ? owner_f : {PAGE_W{1'b0}}), ev_ff, fault_ff,
                         FRAME_W'(f_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      logic [TOK_W-1:0]  tok_out;
      logic [STAT_W-1:0] stat_out;

      dpl_cell #(
         .NUM_FRAMES (NUM_FRAMES),
         .IDX        (g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .limit  (limit),
         .page_i (page_ff),
         .tok_i  (TOK_W'(tok_w[g])),
         .tok_o  (tok_out),
         .cmd_i  (CMD_W'(cmd)),
         .stat_o (stat_out)
      );

      assign tok_w[g+1] = tok_type'(tok_out);
      assign stat_w[g]  = stat_type'(stat_out);
   end

`ifndef ASSERT_OFF
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("page resident in more than one frame");

   a_free_unused: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && fault_ff && !ev_ff) |-> !used_f)
      else $error("free frame pick landed on a used frame");

   a_victim_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && ev_ff) |-> (used_f && fault_ff))
      else $error("eviction of an unused frame");
`endif

endmodule

FILE: design/dpl_cell.sv
// One frame cell of the LRU chain: used flag, owner page and recency rank.
// Passes the free/victim scan token to its neighbor each cycle. Uses dpl_pkg.
module dpl_cell #(
   parameter int NUM_FRAMES = dpl_pkg::NUM_FRAMES_DEF,
   parameter int IDX        = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [$clog2(NUM_FRAMES+1)-1:0]       limit,
   input  logic [dpl_pkg::PAGE_W-1:0]            page_i,
   input  logic [3*((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)+2:0] tok_i,
   output logic [3*((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)+2:0] tok_o,
   input  logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)+$clog2(NUM_FRAMES+1)+1:0] cmd_i,
   output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)+dpl_pkg::PAGE_W+1:0] stat_o
);
   import dpl_pkg::*;

   localparam int FI_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);
   localparam logic [FI_W-1:0]  MY_F   = FI_W'(IDX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
   localparam logic [FI_W-1:0]  TOP_RANK = FI_W'(NUM_FRAMES - 1);

   typedef struct packed {
      logic            vld;
      logic            free_found;
      logic [FI_W-1:0] free_idx;
      logic            have;
      logic [FI_W-1:0] best_rank;
      logic [FI_W-1:0] best_idx;
   } tok_type;

   typedef struct packed {
      logic             touch;
      logic             load;
      logic [FI_W-1:0]  frame;
      logic [CNT_W-1:0] old;
   } cmd_type;

   typedef struct packed {
      logic              used;
      logic              hit;
      logic [PAGE_W-1:0] owner;
      logic [FI_W-1:0]   rank;
   } stat_type;

   tok_type           tok_in, tok_ff, tok_cur;
   cmd_type           cmd;
   stat_type          stat;
   logic              used_ff;
   logic [PAGE_W-1:0] owner_ff;
   logic [FI_W-1:0]   rank_ff;
   logic              in_limit, is_me;

   assign tok_cur  = tok_type'(tok_i);
   assign cmd      = cmd_type'(cmd_i);
   assign in_limit = MY_CNT < limit;
   assign is_me    = cmd.frame == MY_F;

   always_comb begin
      tok_in = tok_cur;
      if (!tok_cur.free_found && !used_ff && in_limit) begin
         tok_in.free_found = 1'b1;
         tok_in.free_idx   = MY_F;
      end
      if (used_ff && in_limit && (!tok_cur.have || rank_ff > tok_cur.best_rank)) begin
         tok_in.have      = 1'b1;
         tok_in.best_rank = rank_ff;
         tok_in.best_idx  = MY_F;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         rank_ff <= '0;
      end else if (cmd.touch) begin
         if (is_me) begin
            used_ff <= 1'b1;
            rank_ff <= '0;
         end else if (used_ff && (CNT_W'(rank_ff) < cmd.old) && (rank_ff < TOP_RANK)) begin
            rank_ff <= rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.touch && cmd.load && is_me) begin
         owner_ff <= page_i;
      end
   end

   always_comb begin
      stat.used  = used_ff;
      stat.hit   = used_ff && (owner_ff == page_i);
      stat.owner = owner_ff;
      stat.rank  = rank_ff;
   end

   assign tok_o  = tok_ff;
   assign stat_o = stat;

endmodule

FILE: tb/demand_paging_lru_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for demand_paging_lru_core: page requests in, frame lookups out,
// predicted by a local LRU page-table model. Depends on dpl_pkg and the core only.
module demand_paging_lru_core_test;
   import dpl_pkg::*;

   localparam int NPAGES      = NUM_PAGES_DEF;
   localparam int NFRAMES     = NUM_FRAMES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int MAX_GAP     = 40;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_number;
      logic               page_fault;
      logic               evicted;
      logic [PAGE_W-1:0]  evicted_page;
   } lookup_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   demand_paging_lru_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic               page_valid_m  [NPAGES];
   logic [FRAME_W-1:0] page_frame_m  [NPAGES];
   logic               frame_used_m  [NFRAMES];
   logic [PAGE_W-1:0]  frame_owner_m [NFRAMES];
   logic [FRAME_W-1:0] frame_rank_m  [NFRAMES];
   logic [CFG_W-1:0]   frames_cfg;

   lookup_type expected_lookups[$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      stall_pct      = 0;
   int      hold_req       = 0;
   int      hold_seen      = 0;
   int      hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TIMEOUT after %0d cycles, %0d lookups pending", CYCLE_LIMIT,
               expected_lookups.size());
      $display("demand_paging_lru_core: mismatch");
      $finish;
   end

   task automatic clear_page_table();
      for (int i = 0; i < NPAGES; i++) begin
         page_valid_m[i] = 1'b0;
         page_frame_m[i] = '0;
      end
      for (int i = 0; i < NFRAMES; i++) begin
         frame_used_m[i]  = 1'b0;
         frame_owner_m[i] = '0;
         frame_rank_m[i]  = '0;
      end
      frames_cfg = FRAMES_RESET;
   endtask

   function automatic int active_frames();
      int n;
      n = frames_cfg;
      if (n < 1) n = 1;
      if (n > NFRAMES) n = NFRAMES;
      return n;
   endfunction

   function automatic lookup_type lookup_page(input logic [PAGE_W-1:0] page);
      lookup_type r;
      int      f;
      int      limit;
      int      best;
      int      old_rank;
      int      i;
      bit      found;
      bit      have;
      r     = '0;
      f     = 0;
      best  = 0;
      found = 1'b0;
      have  = 1'b0;
      if (page_valid_m[page]) begin
         f = page_frame_m[page];
      end else begin
         r.page_fault = 1'b1;
         limit = active_frames();
         for (i = 0; i < limit; i++) begin
            if (!found && !frame_used_m[i]) begin
               f     = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            for (i = 0; i < limit; i++) begin
               if (frame_used_m[i] && (!have || frame_rank_m[i] > best)) begin
                  best = frame_rank_m[i];
                  f    = i;
                  have = 1'b1;
               end
            end
            r.evicted      = 1'b1;
            r.evicted_page = frame_owner_m[f];
            page_valid_m[frame_owner_m[f]] = 1'b0;
         end
         page_valid_m[page] = 1'b1;
         page_frame_m[page] = FRAME_W'(f);
         frame_owner_m[f]   = page;
      end
      old_rank = frame_used_m[f] ? int'(frame_rank_m[f]) : NFRAMES;
      for (i = 0; i < NFRAMES; i++) begin
         if (i != f && frame_used_m[i] && frame_rank_m[i] < old_rank &&
             frame_rank_m[i] < NFRAMES - 1)
            frame_rank_m[i] = frame_rank_m[i] + 1'b1;
      end
      frame_used_m[f] = 1'b1;
      frame_rank_m[f] = '0;
      r.frame_number  = FRAME_W'(f);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // receiver side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch("result with no request pending, tdata", rsp_tdata, 0);
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_tdata[1:0] !== want.frame_number)
               report_mismatch("frame_number", rsp_tdata[1:0], want.frame_number);
            if (rsp_tdata[2] !== want.page_fault)
               report_mismatch("page_fault", rsp_tdata[2], want.page_fault);
            if (rsp_tdata[3] !== want.evicted)
               report_mismatch("evicted", rsp_tdata[3], want.evicted);
            if (rsp_tdata[6:4] !== want.evicted_page)
               report_mismatch("evicted_page", rsp_tdata[6:4], want.evicted_page);
            if (rsp_tdata[7] !== 1'b0)
               report_mismatch("tdata pad bit", rsp_tdata[7], 0);
         end
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 73;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 73;
         end
         default: begin
            send_idle_pct = 14;
            stall_pct     = 14;
         end
      endcase
   endtask

   task automatic send_page(input logic [PAGE_W-1:0] page);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(page);
      do @(posedge clock); while (!req_tready);
      expected_lookups.push_back(lookup_page(page));
   endtask

   task automatic send_pages(input int pages[$]);
      foreach (pages[i]) send_page(PAGE_W'(pages[i]));
   endtask

   // drop valid and hold until every lookup has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (NFRAMES + 4) @(posedge clock);
   endtask

   task automatic write_frames(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      frames_cfg = value;
   endtask

   function automatic logic [PAGE_W-1:0] pick_page(input int base);
      if ($urandom_range(9) < 7)
         return PAGE_W'((base + $urandom_range(active_frames())) % NPAGES);
      return PAGE_W'($urandom_range(NPAGES - 1));
   endfunction

   task automatic test_directed();
      set_idling(IDLE_NONE);
      send_pages('{0, 1, 2, 3, 0, 4, 1, 7, 7});
      wait_drained();
      write_frames(3'd2);
      send_pages('{7, 1, 6, 5, 7});
      wait_drained();
      write_frames(3'd0);
      send_pages('{3, 3, 2});
      wait_drained();
      write_frames(3'd7);
      send_pages('{0, 6, 5, 4});
      wait_drained();
   endtask

   task automatic test_backpressure();
      int base;
      write_frames(3'd4);
      set_idling(IDLE_NONE);
      hold_req <= hold_req + 1;
      base = $urandom_range(NPAGES - 1);
      repeat (40) send_page(pick_page(base));
      wait_drained();
      set_idling(IDLE_RECEIVER);
      repeat (20) send_page(pick_page(base));
      wait_drained();
   endtask

   task automatic test_random();
      int base;
      for (int chunk = 0; chunk < 16; chunk++) begin
         write_frames(CFG_W'((chunk * 3) % 8));
         set_idling(idle_mode_type'(chunk % 4));
         base = $urandom_range(NPAGES - 1);
         for (int n = 0; n < 75; n++) begin
            if ($urandom_range(24) == 0) base = $urandom_range(NPAGES - 1);
            send_page(pick_page(base));
         end
         wait_drained();
      end
   endtask

   initial begin
      clear_page_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      wait_drained();
      if (mismatch_count == 0)
         $display("demand_paging_lru_core: match");
      else
         $display("demand_paging_lru_core: mismatch");
      $finish;
   end

endmodule
